// ===== design/gbtf_pkg.sv =====
// ----------------------------------------------------------------------------
// gbtf_pkg
// Shared types and constants for the grid border trace and fill core.
// ----------------------------------------------------------------------------
package gbtf_pkg;

   // default geometry
   localparam int ROWS_DEF      = 64;
   localparam int COLS_DEF      = 64;
   localparam int MAX_STEPS_DEF = 32;

   // signed trace coordinate, wide enough for 255 repeats of 33 moves
   localparam int POS_W = 16;

   localparam int LABEL_W = 4;
   localparam logic [LABEL_W-1:0] FILL_LABEL = 4'd9;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_NEG_STEPS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEG_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_STEPS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_NZ   = 3'd4;

   // command codes
   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_TRACE = 2'd1,
      MODE_FILL  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // chain code step directions
   localparam logic [1:0] STEP_RIGHT = 2'd0;
   localparam logic [1:0] STEP_DOWN  = 2'd1;
   localparam logic [1:0] STEP_LEFT  = 2'd2;
   localparam logic [1:0] STEP_UP    = 2'd3;

endpackage

// ===== design/grid_border_trace_and_fill_core.sv =====
// ----------------------------------------------------------------------------
// grid_border_trace_and_fill_core
// Chain code border trace and scanline parity fill over a grid of labels.
// ----------------------------------------------------------------------------
// One command at a time; busy is high until its result beat, which the
//   receiver cannot stall. Trace marks one cell a cycle, fill scans one cell
//   a cycle through the single read port of the grid memory.
// After reset a clearing pass zeroes the grid, busy high.
module grid_border_trace_and_fill_core #(
   parameter int ROWS      = gbtf_pkg::ROWS_DEF,
   parameter int COLS      = gbtf_pkg::COLS_DEF,
   parameter int MAX_STEPS = gbtf_pkg::MAX_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [5:0]                      req_row,
   input  logic [5:0]                      req_col,
   input  logic [3:0]                      req_label,
   input  logic [7:0]                      req_repeat_count,
   input  logic                            req_slope,
   // result
   output logic                            rsp_valid,
   output logic [3:0]                      rsp_cell_value,
   output logic                            rsp_clipped,
   // configuration
   input  logic                            csr_we,
   input  logic [gbtf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbtf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLS);
   localparam int PW    = gbtf_pkg::POS_W;
   localparam int LW    = gbtf_pkg::LABEL_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
   localparam logic signed [PW-1:0] ROWS_S = PW'(ROWS);
   localparam logic signed [PW-1:0] COLS_S = PW'(COLS);
   localparam logic [5:0] MAX_LEN = 6'(MAX_STEPS);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_TRACE,
      S_FILL,
      S_READ
   } state_type;

   function automatic logic in_grid(logic signed [PW-1:0] r, logic signed [PW-1:0] c);
      return (r >= 0) && (r < ROWS_S) && (c >= 0) && (c < COLS_S);
   endfunction

   function automatic logic [AW-1:0] cell_addr(logic signed [PW-1:0] r,
                                               logic signed [PW-1:0] c);
      return AW'(r) * AW'(COLS) + AW'(c);
   endfunction

   // configuration registers
   logic [63:0] neg_steps_ff, pos_steps_ff;
   logic [5:0]  neg_len_ff, pos_len_ff;
   logic        coef_nz_ff;

   // control state
   state_type   state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic signed [PW-1:0] pos_r_ff, pos_r_in, pos_c_ff, pos_c_in;
   logic [LW-1:0] label_ff, label_in;
   logic [7:0]  reps_ff, reps_in, rep_ff, rep_in;
   logic        slope_ff, slope_in;
   logic [5:0]  k_ff, k_in;
   logic        clip_ff, clip_in;
   logic        rd_ok_ff, rd_ok_in;
   // fill scan
   logic [AW-1:0] fill_addr_ff, fill_addr_in, p_addr_ff, p_addr_in;
   logic [CW-1:0] fcol_ff, fcol_in, p_col_ff, p_col_in;
   logic        issue_done_ff, issue_done_in, p_valid_ff, p_valid_in;
   logic        inside_ff, inside_in;
   logic [LW-1:0] last_ff, last_in, prev_ff, prev_in;
   // result beat
   logic        rsp_valid_ff, rsp_valid_in, rsp_clip_ff, rsp_clip_in;
   logic [LW-1:0] rsp_value_ff, rsp_value_in;

   // memory access
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [LW-1:0] mem_wdata, mem_rdata;

   // request decode
   logic signed [PW-1:0] req_r, req_c;
   logic          req_ok;
   logic [AW-1:0] req_addr;
   logic [63:0]   path;
   logic [5:0]    len_raw, len_eff;

   assign req_r    = PW'(req_row);
   assign req_c    = PW'(req_col);
   assign req_ok   = in_grid(req_r, req_c);
   assign req_addr = cell_addr(req_r, req_c);
   assign path     = slope_ff ? pos_steps_ff : neg_steps_ff;
   assign len_raw  = slope_ff ? pos_len_ff : neg_len_ff;
   assign len_eff  = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;

   gbtf_grid_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // next state and memory control
   always_comb begin
      logic signed [PW-1:0] sr, sc;
      logic                 mark;
      logic                 ins;
      logic [LW-1:0]        lst;
      sr = pos_r_ff;
      sc = pos_c_ff;
      mark = 1'b0;
      ins = 1'b0;
      lst = '0;
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      pos_r_in      = pos_r_ff;
      pos_c_in      = pos_c_ff;
      label_in      = label_ff;
      reps_in       = reps_ff;
      rep_in        = rep_ff;
      slope_in      = slope_ff;
      k_in          = k_ff;
      clip_in       = clip_ff;
      rd_ok_in      = rd_ok_ff;
      fill_addr_in  = fill_addr_ff;
      p_addr_in     = p_addr_ff;
      fcol_in       = fcol_ff;
      p_col_in      = p_col_ff;
      issue_done_in = issue_done_ff;
      p_valid_in    = 1'b0;
      inside_in     = inside_ff;
      last_in       = last_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = 1'b0;
      rsp_clip_in   = 1'b0;
      rsp_value_in  = '0;
      mem_we        = 1'b0;
      mem_waddr     = clr_addr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = fill_addr_ff;

      unique case (state_ff)
         // zero the grid after reset
         S_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               unique case (gbtf_pkg::mode_type'(req_mode))
                  gbtf_pkg::MODE_WRITE: begin
                     mem_we       = req_ok;
                     mem_waddr    = req_addr;
                     mem_wdata    = req_label;
                     rsp_valid_in = 1'b1;
                     rsp_clip_in  = !req_ok;
                  end
                  gbtf_pkg::MODE_TRACE: begin
                     mem_we    = req_ok;
                     mem_waddr = req_addr;
                     mem_wdata = req_label;
                     pos_r_in  = req_r;
                     pos_c_in  = req_c;
                     label_in  = req_label;
                     reps_in   = req_repeat_count;
                     slope_in  = req_slope;
                     clip_in   = !req_ok;
                     rep_in    = '0;
                     k_in      = '0;
                     if (req_repeat_count == 8'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_clip_in  = !req_ok;
                     end else begin
                        state_in = S_TRACE;
                     end
                  end
                  gbtf_pkg::MODE_FILL: begin
                     fill_addr_in  = '0;
                     fcol_in       = '0;
                     issue_done_in = 1'b0;
                     state_in      = S_FILL;
                  end
                  gbtf_pkg::MODE_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = req_addr;
                     rd_ok_in  = req_ok;
                     state_in  = S_READ;
                  end
                  default: ;
               endcase
            end
         end

         // one mark per cycle: path steps, then a diagonal between repeats
         S_TRACE: begin
            if (k_ff < len_eff) begin
               case (path[{k_ff[4:0], 1'b0} +: 2])
                  gbtf_pkg::STEP_RIGHT: sc = pos_c_ff + 1'b1;
                  gbtf_pkg::STEP_DOWN:  sr = pos_r_ff + 1'b1;
                  gbtf_pkg::STEP_LEFT:  sc = pos_c_ff - 1'b1;
                  default:              sr = pos_r_ff - 1'b1;
               endcase
               mark = 1'b1;
               k_in = k_ff + 1'b1;
            end else if ({1'b0, rep_ff} + 9'd1 == {1'b0, reps_ff}) begin
               rsp_valid_in = 1'b1;
               rsp_clip_in  = clip_ff;
               state_in     = S_IDLE;
            end else begin
               if (!slope_ff) begin
                  sc = pos_c_ff + 1'b1;
                  if (coef_nz_ff) sr = pos_r_ff + 1'b1;
               end else begin
                  sr = pos_r_ff - 1'b1;
                  if (coef_nz_ff) sc = pos_c_ff + 1'b1;
               end
               mark   = 1'b1;
               rep_in = rep_ff + 1'b1;
               k_in   = '0;
            end
            if (mark) begin
               pos_r_in  = sr;
               pos_c_in  = sc;
               mem_we    = in_grid(sr, sc);
               mem_waddr = cell_addr(sr, sc);
               mem_wdata = label_ff;
               clip_in   = clip_ff | !in_grid(sr, sc);
            end
         end

         // stream reads in address order, decide from the registered read data
         S_FILL: begin
            if (!issue_done_ff) begin
               mem_re       = 1'b1;
               mem_raddr    = fill_addr_ff;
               p_valid_in   = 1'b1;
               p_addr_in    = fill_addr_ff;
               p_col_in     = fcol_ff;
               fill_addr_in = fill_addr_ff + 1'b1;
               fcol_in      = (fcol_ff == LAST_COL) ? '0 : fcol_ff + 1'b1;
               if (fill_addr_ff == LAST_ADDR) issue_done_in = 1'b1;
            end
            if (p_valid_ff) begin
               if (coef_nz_ff) begin
                  // label change parity, cell under decision is the one just read
                  ins = (p_col_ff == '0) ? 1'b0 : inside_ff;
                  lst = (p_col_ff == '0) ? '0 : last_ff;
                  inside_in = ins;
                  last_in   = lst;
                  if (mem_rdata != '0) begin
                     if (mem_rdata != lst) begin
                        inside_in = !ins;
                        last_in   = mem_rdata;
                     end
                  end else if (ins) begin
                     mem_we    = 1'b1;
                     mem_waddr = p_addr_ff;
                     mem_wdata = gbtf_pkg::FILL_LABEL;
                  end
               end else begin
                  // border run parity, decide the previous cell with its right neighbour
                  if (p_col_ff != '0) begin
                     ins = (p_col_ff == CW'(1)) ? 1'b0 : inside_ff;
                     inside_in = ins;
                     if (prev_ff != '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = p_addr_ff - 1'b1;
                        mem_wdata = gbtf_pkg::FILL_LABEL;
                        inside_in = ins ^ (mem_rdata == '0);
                     end else if (ins) begin
                        mem_we    = 1'b1;
                        mem_waddr = p_addr_ff - 1'b1;
                        mem_wdata = gbtf_pkg::FILL_LABEL;
                     end
                  end
                  prev_in = mem_rdata;
               end
               if (p_addr_ff == LAST_ADDR) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end

         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_ok_ff ? mem_rdata : '0;
            state_in     = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_r_ff      <= pos_r_in;
      pos_c_ff      <= pos_c_in;
      label_ff      <= label_in;
      reps_ff       <= reps_in;
      rep_ff        <= rep_in;
      slope_ff      <= slope_in;
      k_ff          <= k_in;
      clip_ff       <= clip_in;
      rd_ok_ff      <= rd_ok_in;
      fill_addr_ff  <= fill_addr_in;
      p_addr_ff     <= p_addr_in;
      fcol_ff       <= fcol_in;
      p_col_ff      <= p_col_in;
      issue_done_ff <= issue_done_in;
      inside_ff     <= inside_in;
      last_ff       <= last_in;
      prev_ff       <= prev_in;
      rsp_clip_ff   <= rsp_clip_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         neg_steps_ff <= '0;
         neg_len_ff   <= '0;
         pos_steps_ff <= '0;
         pos_len_ff   <= '0;
         coef_nz_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            gbtf_pkg::CSR_NEG_STEPS: neg_steps_ff <= csr_wdata;
            gbtf_pkg::CSR_NEG_LEN:   neg_len_ff   <= csr_wdata[5:0];
            gbtf_pkg::CSR_POS_STEPS: pos_steps_ff <= csr_wdata;
            gbtf_pkg::CSR_POS_LEN:   pos_len_ff   <= csr_wdata[5:0];
            gbtf_pkg::CSR_COEF_NZ:   coef_nz_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_clipped    = rsp_clip_ff;

endmodule

// ===== design/gbtf_grid_mem.sv =====
// ----------------------------------------------------------------------------
// gbtf_grid_mem
// Cell label store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbtf_grid_mem #(
   parameter int DEPTH = gbtf_pkg::ROWS_DEF * gbtf_pkg::COLS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [gbtf_pkg::LABEL_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [gbtf_pkg::LABEL_W-1:0] rd_data
);

   logic [gbtf_pkg::LABEL_W-1:0] mem [DEPTH];
   logic [gbtf_pkg::LABEL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
